>>> design/wvs_pkg.sv
// Shared constants, types and saturation helpers for the 2D vertex skinning block.
package wvs_pkg;

  // Field and state widths.
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned WEIGHT_W     = 17;
  localparam int unsigned SUM_W        = 48;
  localparam int unsigned WIDE_W       = 72;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MX0,
    ST_MX1,
    ST_MY0,
    ST_MY1,
    ST_WY,
    ST_TY,
    ST_SY,
    ST_FIN
  } state_e;

  // Matrix entry that feeds the shared matrix multiplier.
  typedef enum logic [1:0] {
    MAT_A,
    MAT_B,
    MAT_C,
    MAT_D
  } mat_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     in_ready;
    logic     mat_en;
    mat_sel_e mat_sel;
    logic     clip_x;
    logic     clip_y;
    logic     wmul;
    logic     sum_x;
    logic     sum_y;
    logic     finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic last;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [SUM_W-1:0] val;
  } sat_sum_t;

  typedef struct packed {
    logic                      ovf;
    logic signed [COORD_W-1:0] val;
  } sat_coord_t;

  // Clip a wide signed value to the signed sum range.
  function automatic sat_sum_t sat_sum(input logic signed [WIDE_W-1:0] v);
    sat_sum_t r;
    logic     all_one;
    logic     all_zero;
    all_one  = &v[WIDE_W-1:SUM_W-1];
    all_zero = ~|v[WIDE_W-1:SUM_W-1];
    r.ovf    = !(all_one || all_zero);
    if (r.ovf) begin
      r.val = v[WIDE_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r.val = v[SUM_W-1:0];
    end
    return r;
  endfunction

  // Clip a sum plus origin to the signed coordinate range.
  function automatic sat_coord_t sat_coord(input logic signed [SUM_W:0] v);
    sat_coord_t r;
    logic       all_one;
    logic       all_zero;
    all_one  = &v[SUM_W:COORD_W-1];
    all_zero = ~|v[SUM_W:COORD_W-1];
    r.ovf    = !(all_one || all_zero);
    if (r.ovf) begin
      r.val = v[SUM_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r.val = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/wvs_item_if.sv
// Influence request channel: valid, ready and one bone influence.
interface wvs_item_if;
  logic                                valid;
  logic                                ready;
  logic signed [wvs_pkg::COORD_W-1:0]  local_x;
  logic signed [wvs_pkg::COORD_W-1:0]  local_y;
  logic signed [wvs_pkg::COORD_W-1:0]  deform_x;
  logic signed [wvs_pkg::COORD_W-1:0]  deform_y;
  logic        [wvs_pkg::WEIGHT_W-1:0] blend_weight;
  logic signed [wvs_pkg::COORD_W-1:0]  m_a;
  logic signed [wvs_pkg::COORD_W-1:0]  m_b;
  logic signed [wvs_pkg::COORD_W-1:0]  m_c;
  logic signed [wvs_pkg::COORD_W-1:0]  m_d;
  logic signed [wvs_pkg::COORD_W-1:0]  bone_pos_x;
  logic signed [wvs_pkg::COORD_W-1:0]  bone_pos_y;
  logic                                last_influence;

  modport source (
    output valid, local_x, local_y, deform_x, deform_y, blend_weight,
           m_a, m_b, m_c, m_d, bone_pos_x, bone_pos_y, last_influence,
    input  ready
  );

  modport sink (
    input  valid, local_x, local_y, deform_x, deform_y, blend_weight,
           m_a, m_b, m_c, m_d, bone_pos_x, bone_pos_y, last_influence,
    output ready
  );
endinterface

>>> design/wvs_vertex_if.sv
// Vertex result channel: valid, ready and one world vertex.
interface wvs_vertex_if;
  logic                               valid;
  logic                               ready;
  logic signed [wvs_pkg::COORD_W-1:0] world_x;
  logic signed [wvs_pkg::COORD_W-1:0] world_y;
  logic                               saturated;

  modport source (
    output valid, world_x, world_y, saturated,
    input  ready
  );

  modport sink (
    input  valid, world_x, world_y, saturated,
    output ready
  );
endinterface

>>> design/wvs_ctrl.sv
// Sequencer that steps one influence through the shared multipliers.
module wvs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wvs_pkg::status_t status_i,
  output wvs_pkg::cmd_t    cmd_o
);

  wvs_pkg::state_e state_q;
  wvs_pkg::state_e state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wvs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mat_sel = wvs_pkg::MAT_A;
    case (state_q)
      wvs_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          state_d = wvs_pkg::ST_MX0;
        end
      end
      wvs_pkg::ST_MX0: begin
        cmd_o.mat_en  = 1'b1;
        cmd_o.mat_sel = wvs_pkg::MAT_A;
        state_d       = wvs_pkg::ST_MX1;
      end
      wvs_pkg::ST_MX1: begin
        cmd_o.mat_en  = 1'b1;
        cmd_o.mat_sel = wvs_pkg::MAT_B;
        state_d       = wvs_pkg::ST_MY0;
      end
      // The x position is complete here, so it is clipped alongside.
      wvs_pkg::ST_MY0: begin
        cmd_o.mat_en  = 1'b1;
        cmd_o.mat_sel = wvs_pkg::MAT_C;
        cmd_o.clip_x  = 1'b1;
        state_d       = wvs_pkg::ST_MY1;
      end
      wvs_pkg::ST_MY1: begin
        cmd_o.mat_en  = 1'b1;
        cmd_o.mat_sel = wvs_pkg::MAT_D;
        cmd_o.wmul    = 1'b1;
        state_d       = wvs_pkg::ST_WY;
      end
      wvs_pkg::ST_WY: begin
        cmd_o.clip_y = 1'b1;
        cmd_o.sum_x  = 1'b1;
        state_d      = wvs_pkg::ST_TY;
      end
      wvs_pkg::ST_TY: begin
        cmd_o.wmul = 1'b1;
        state_d    = wvs_pkg::ST_SY;
      end
      wvs_pkg::ST_SY: begin
        cmd_o.sum_y = 1'b1;
        state_d     = status_i.last ? wvs_pkg::ST_FIN : wvs_pkg::ST_IDLE;
      end
      // Hold the finished vertex until the output register is free.
      wvs_pkg::ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = wvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wvs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/wvs_dpath.sv
// Datapath: operand registers, shared multipliers, sums and output register.
module wvs_dpath #(
  parameter int unsigned FRAC_BITS = wvs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wvs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wvs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  wvs_item_if.sink                          item,
  wvs_vertex_if.source                      result,
  input  wvs_pkg::cmd_t                     cmd_i,
  output wvs_pkg::status_t                  status_o
);

  localparam int unsigned VEC_W  = wvs_pkg::COORD_W + 1;
  localparam int unsigned MAT_W  = VEC_W + wvs_pkg::COORD_W;
  localparam int unsigned ACC_W  = MAT_W - FRAC_BITS + 2;
  localparam int unsigned WOP_W  = wvs_pkg::WEIGHT_W + 1;
  localparam int unsigned WPR_W  = wvs_pkg::SUM_W + WOP_W;
  localparam int unsigned TERM_W = WPR_W - FRAC_BITS;

  // Operand registers of the influence being worked on.
  logic signed [VEC_W-1:0]            vx_q, vy_q;
  logic signed [wvs_pkg::COORD_W-1:0] ma_q, mb_q, mc_q, md_q;
  logic        [wvs_pkg::WEIGHT_W-1:0] w_q;
  logic                               last_q;

  // Working registers.
  logic signed [ACC_W-1:0]            acc_x_q, acc_y_q;
  logic signed [wvs_pkg::SUM_W-1:0]   pc_q;
  logic signed [TERM_W-1:0]           term_q;

  // Control state.
  logic signed [wvs_pkg::SUM_W-1:0]   sum_x_q, sum_y_q;
  logic                               clip_seen_q, clip_seen_d;
  logic signed [wvs_pkg::COORD_W-1:0] origin_x_q, origin_y_q;
  logic                               out_valid_q;
  logic signed [wvs_pkg::COORD_W-1:0] world_x_q, world_y_q;
  logic                               sat_q;

  logic                               load;
  logic signed [VEC_W-1:0]            mat_op_a;
  logic signed [wvs_pkg::COORD_W-1:0] mat_op_b;
  logic signed [MAT_W-1:0]            mat_prod;
  logic signed [ACC_W-1:0]            mat_term;
  logic signed [WOP_W-1:0]            w_op;
  logic signed [WPR_W-1:0]            w_prod;
  wvs_pkg::sat_sum_t                  clip_px, clip_py, new_sum_x, new_sum_y;
  wvs_pkg::sat_coord_t                out_x, out_y;

  assign load            = cmd_i.in_ready && item.valid;
  assign item.ready      = cmd_i.in_ready;
  assign status_o.in_valid = item.valid;
  assign status_o.last     = last_q;
  assign status_o.out_free = !out_valid_q || result.ready;

  // Shared matrix multiplier: one product of the 2x2 transform per step.
  always_comb begin
    case (cmd_i.mat_sel)
      wvs_pkg::MAT_A: begin
        mat_op_a = vx_q;
        mat_op_b = ma_q;
      end
      wvs_pkg::MAT_B: begin
        mat_op_a = vy_q;
        mat_op_b = mb_q;
      end
      wvs_pkg::MAT_C: begin
        mat_op_a = vx_q;
        mat_op_b = mc_q;
      end
      wvs_pkg::MAT_D: begin
        mat_op_a = vy_q;
        mat_op_b = md_q;
      end
      default: begin
        mat_op_a = vx_q;
        mat_op_b = ma_q;
      end
    endcase
  end

  assign mat_prod = mat_op_a * mat_op_b;
  // Dropping the fraction bits of a two's complement value rounds toward minus infinity.
  assign mat_term = ACC_W'($signed(mat_prod[MAT_W-1:FRAC_BITS]));

  // Shared weight multiplier on the clipped position.
  assign w_op   = $signed({1'b0, w_q});
  assign w_prod = pc_q * w_op;

  assign clip_px   = wvs_pkg::sat_sum(wvs_pkg::WIDE_W'(acc_x_q));
  assign clip_py   = wvs_pkg::sat_sum(wvs_pkg::WIDE_W'(acc_y_q));
  assign new_sum_x = wvs_pkg::sat_sum(wvs_pkg::WIDE_W'(sum_x_q) + wvs_pkg::WIDE_W'(term_q));
  assign new_sum_y = wvs_pkg::sat_sum(wvs_pkg::WIDE_W'(sum_y_q) + wvs_pkg::WIDE_W'(term_q));
  assign out_x = wvs_pkg::sat_coord((wvs_pkg::SUM_W + 1)'(sum_x_q)
                                    + (wvs_pkg::SUM_W + 1)'(origin_x_q));
  assign out_y = wvs_pkg::sat_coord((wvs_pkg::SUM_W + 1)'(sum_y_q)
                                    + (wvs_pkg::SUM_W + 1)'(origin_y_q));

  // Sticky clip record for the vertex in progress.
  always_comb begin
    clip_seen_d = clip_seen_q;
    if (cmd_i.clip_x && clip_px.ovf) clip_seen_d = 1'b1;
    if (cmd_i.clip_y && clip_py.ovf) clip_seen_d = 1'b1;
    if (cmd_i.sum_x && new_sum_x.ovf) clip_seen_d = 1'b1;
    if (cmd_i.sum_y && new_sum_y.ovf) clip_seen_d = 1'b1;
    if (cmd_i.finish) clip_seen_d = 1'b0;
  end

  // Operand, working and output data registers.
  always_ff @(posedge clk_i) begin
    if (load) begin
      vx_q    <= VEC_W'(item.local_x) + VEC_W'(item.deform_x);
      vy_q    <= VEC_W'(item.local_y) + VEC_W'(item.deform_y);
      ma_q    <= item.m_a;
      mb_q    <= item.m_b;
      mc_q    <= item.m_c;
      md_q    <= item.m_d;
      w_q     <= item.blend_weight;
      last_q  <= item.last_influence;
      acc_x_q <= ACC_W'(item.bone_pos_x);
      acc_y_q <= ACC_W'(item.bone_pos_y);
    end else if (cmd_i.mat_en) begin
      if (cmd_i.mat_sel == wvs_pkg::MAT_A || cmd_i.mat_sel == wvs_pkg::MAT_B) begin
        acc_x_q <= acc_x_q + mat_term;
      end else begin
        acc_y_q <= acc_y_q + mat_term;
      end
    end
    if (cmd_i.clip_x) begin
      pc_q <= clip_px.val;
    end else if (cmd_i.clip_y) begin
      pc_q <= clip_py.val;
    end
    if (cmd_i.wmul) begin
      term_q <= w_prod[WPR_W-1:FRAC_BITS];
    end
    if (cmd_i.finish) begin
      world_x_q <= out_x.val;
      world_y_q <= out_y.val;
      sat_q     <= clip_seen_q | out_x.ovf | out_y.ovf;
    end
  end

  // Running sums, clip record, origin registers and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      clip_seen_q <= 1'b0;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clip_seen_q <= clip_seen_d;
      if (cmd_i.finish) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
      end else begin
        if (cmd_i.sum_x) sum_x_q <= new_sum_x.val;
        if (cmd_i.sum_y) sum_y_q <= new_sum_y.val;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (result.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          wvs_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
          wvs_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  assign result.valid     = out_valid_q;
  assign result.world_x   = world_x_q;
  assign result.world_y   = world_y_q;
  assign result.saturated = sat_q;

endmodule

>>> design/weighted_vertex_skinning_2d.sv
// Top level of the 2D weighted vertex skinning block.
//
//   channel   direction  request carries
//   item_i    in         one bone influence (offsets, weight, matrix, position, last flag)
//   result_o  out        one world vertex (world_x, world_y, saturated)
//   cfg_*_i   in         origin_x / origin_y register writes
//
// An influence is accepted in ST_IDLE and then takes four steps of the shared
// 33x32 matrix multiplier and three for the clip, weight product and sum of y.
// The influence that ends a vertex then loads the output register once that
// register is free, waiting while it stays full and ready is low.
// Reset clears the sums, the clip record, the origin registers and the output valid.
// A stalled result does not block the input once the vertex has been handed over.
module weighted_vertex_skinning_2d #(
  parameter int unsigned FRAC_BITS = wvs_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wvs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wvs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  wvs_item_if.sink                       item_i,
  wvs_vertex_if.source                   result_o
);

  wvs_pkg::cmd_t    cmd;
  wvs_pkg::status_t status;

  wvs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  wvs_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item        (item_i),
    .result      (result_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
